@@ rtl/wildcard_nibble_pattern_scan_macros.svh @@
// Assertion macros shared by the checker of the wildcard nibble pattern scan.
`ifndef WILDCARD_NIBBLE_PATTERN_SCAN_MACROS_SVH
`define WILDCARD_NIBBLE_PATTERN_SCAN_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define WNPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define WNPS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ rtl/wnps_pkg.sv @@
// Package with the constants, register indexes and cell types of the pattern scan.
`default_nettype none

package wnps_pkg;

	localparam int PATTERN_BYTES = 16;
	localparam int REG_BYTES     = 16;
	localparam int PAT_IDX_W     = $clog2(REG_BYTES);
	localparam int DATA_W        = 8;
	localparam int ADDR_W        = 64;
	localparam int LEN_W         = 5;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 64;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CARE_LOW      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CARE_HIGH     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 3'd5;

	typedef struct packed {
		logic              used;
		logic [DATA_W-1:0] pat;
		logic [DATA_W-1:0] care;
	} cell_cfg_t;

	// A length of zero counts as one byte, and lengths beyond the row of cells saturate.
	function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
		if (len == '0) begin
			return LEN_W'(1);
		end
		if (len > LEN_W'(PATTERN_BYTES)) begin
			return LEN_W'(PATTERN_BYTES);
		end
		return len;
	endfunction

endpackage

`default_nettype wire

@@ rtl/wildcard_nibble_pattern_scan.sv @@
// Top level of the wildcard nibble pattern scan over a byte stream.
//
// The block takes one byte request per clock cycle while in_stall is low and reports the
// first position in the range where the configured pattern matches, comparing only the
// bits enabled in the care mask. The bytes shift through a row of sixteen cells, and all
// cells compare their byte against the pattern in parallel in the cycle after the byte is
// taken. A found or not-found result is registered in the inner stage, which holds the
// match decision and the address offset from the cell compare, and then in the output
// register, which adds the base address. Without output stall the throughput is one byte
// per cycle, and a result waiting in the output register does not stop new bytes while
// the inner stage is free. Configuration must be written only while no request is in
// flight; the block itself does not enforce this.
`default_nettype none

module wildcard_nibble_pattern_scan (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [wnps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wnps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [wnps_pkg::DATA_W-1:0]     data_byte,
	input  logic                            last_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            found,
	output logic [wnps_pkg::ADDR_W-1:0]     match_address
);
	import wnps_pkg::*;

	logic [ADDR_W-1:0]     base_q;
	logic [CFG_DATA_W-1:0] pat_lo_q;
	logic [CFG_DATA_W-1:0] pat_hi_q;
	logic [CFG_DATA_W-1:0] care_lo_q;
	logic [CFG_DATA_W-1:0] care_hi_q;
	logic [LEN_W-1:0]      len_q;

	logic [LEN_W-1:0]      len_eff;
	logic [2*CFG_DATA_W-1:0] pat_all;
	logic [2*CFG_DATA_W-1:0] care_all;
	logic [DATA_W-1:0]     pat_b [REG_BYTES];
	logic [DATA_W-1:0]     care_b [REG_BYTES];
	logic [DATA_W-1:0]     win [PATTERN_BYTES];
	logic [PATTERN_BYTES-1:0] cell_ok;

	logic                  accept;
	logic                  o_free;
	logic                  s2_free;
	logic                  enough;
	logic                  hit;
	logic                  emit;
	logic [ADDR_W-1:0]     count_next;

	logic [ADDR_W-1:0]     cnt_q;
	logic                  done_q;
	logic                  valid_s1;
	logic [ADDR_W-1:0]     count_s1;
	logic                  last_s1;
	logic                  valid_s2;
	logic                  found_s2;
	logic [ADDR_W-1:0]     offset_s2;
	logic                  out_valid_q;
	logic                  found_q;
	logic [ADDR_W-1:0]     addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			care_lo_q <= '0;
			care_hi_q <= '0;
			len_q     <= LEN_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BASE_ADDRESS: base_q    <= cfg_data;
				REG_PATTERN_LOW:  pat_lo_q  <= cfg_data;
				REG_PATTERN_HIGH: pat_hi_q  <= cfg_data;
				REG_CARE_LOW:     care_lo_q <= cfg_data;
				REG_CARE_HIGH:    care_hi_q <= cfg_data;
				REG_PATTERN_LEN:  len_q     <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign len_eff  = eff_length(len_q);
	assign pat_all  = {pat_hi_q, pat_lo_q};
	assign care_all = {care_hi_q, care_lo_q};

	always_comb begin
		for (int i = 0; i < REG_BYTES; i++) begin
			pat_b[i]  = pat_all[i*DATA_W +: DATA_W];
			care_b[i] = care_all[i*DATA_W +: DATA_W];
		end
	end

	// Cell k holds the byte seen k requests ago and meets pattern byte len - 1 - k.
	for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_cell
		logic [LEN_W-1:0] sel;
		cell_cfg_t        ccfg;
		logic [DATA_W-1:0] feed;

		assign sel       = len_eff - LEN_W'(k + 1);
		assign ccfg.used = LEN_W'(k) < len_eff;
		assign ccfg.pat  = pat_b[sel[PAT_IDX_W-1:0]];
		assign ccfg.care = care_b[sel[PAT_IDX_W-1:0]];

		if (k == 0) begin : g_head
			assign feed = data_byte;
		end else begin : g_body
			assign feed = win[k-1];
		end

		wnps_cell u_cell (
			.clk      (clk),
			.shift    (accept),
			.byte_in  (feed),
			.cfg      (ccfg),
			.byte_out (win[k]),
			.ok       (cell_ok[k])
		);
	end

	assign o_free   = !out_valid_q || !out_stall;
	assign s2_free  = !valid_s2 || o_free;
	assign in_stall = valid_s1 && !s2_free;
	assign accept   = in_valid && !in_stall;

	assign count_next = (&cnt_q) ? cnt_q : cnt_q + ADDR_W'(1);

	assign enough = (|count_s1[ADDR_W-1:LEN_W]) || (count_s1[LEN_W-1:0] >= len_eff);
	assign hit    = !done_q && enough && (&cell_ok);
	assign emit   = hit || (last_s1 && !done_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			done_q      <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= last_byte ? '0 : count_next;
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (valid_s1 && s2_free) begin
				done_q <= last_s1 ? 1'b0 : (done_q || hit);
			end
			if (s2_free) begin
				valid_s2 <= valid_s1 && emit;
			end
			if (o_free) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			count_s1 <= count_next;
			last_s1  <= last_byte;
		end
		if (valid_s1 && s2_free && emit) begin
			found_s2  <= hit;
			offset_s2 <= count_s1 - ADDR_W'(len_eff);
		end
		if (valid_s2 && o_free) begin
			found_q <= found_s2;
			addr_q  <= found_s2 ? base_q + offset_s2 : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign match_address = addr_q;

endmodule

`default_nettype wire

@@ rtl/wnps_cell.sv @@
// One cell of the byte window: holds one byte, passes it on, and compares it.
`default_nettype none

module wnps_cell (
	input  logic                        clk,
	input  logic                        shift,
	input  logic [wnps_pkg::DATA_W-1:0] byte_in,
	input  wnps_pkg::cell_cfg_t         cfg,
	output logic [wnps_pkg::DATA_W-1:0] byte_out,
	output logic                        ok
);
	import wnps_pkg::*;

	logic [DATA_W-1:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;
	assign ok       = !cfg.used || (((byte_q ^ cfg.pat) & cfg.care) == '0);

endmodule

`default_nettype wire

@@ rtl/wnps_checker.sv @@
// Port checker for the wildcard nibble pattern scan, bound to its top level.
`default_nettype none

`include "wildcard_nibble_pattern_scan_macros.svh"

module wnps_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        found,
	input logic [wnps_pkg::ADDR_W-1:0] match_address
);
	import wnps_pkg::*;

	`WNPS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(match_address), "stalled result changed")
	`WNPS_NEVER(a_notfound_zero, out_valid && !found && (match_address != '0), "not-found result carries an address")
	`WNPS_NEVER(a_no_stall_when_drained, (!out_valid || !out_stall) && in_stall, "input stalled while output drains")
	`WNPS_ASSERT(a_in_ready_after_reset, $rose(arst_n) |-> !in_stall, "input stalled right after reset")

endmodule

bind wildcard_nibble_pattern_scan wnps_checker u_wnps_checker (.*);

`default_nettype wire
